/* src/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;

  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int LEN_W       = 4;
  localparam int LANE_W      = 3;
  localparam int LIMIT_W     = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACE_ALL        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_REPLACEMENTS   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_TRIM,
    ST_SCAN,
    ST_REPL,
    ST_LIM_DRAIN,
    ST_LIM_BYTE,
    ST_END
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_OLDEST,
    EMIT_CUR,
    EMIT_REPL
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  append;
    emit_t emit;
    logic  repl_done;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    logic limit;
    logic count_zero;
    logic count_full;
    logic over_plen;
    logic prefix;
    logic at_plen;
    logic repl_more;
    logic emit_ok;
    logic cur_last;
  } status_t;

endpackage

/* src/sfr_ctrl.sv */
// Controller state machine sequencing append, trim, scan, replace and flush.
module sfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfr_pkg::status_t status,
  output sfr_pkg::cmd_t    cmd
);
  import sfr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.limit ? ST_LIM_DRAIN : ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (!status.count_full) begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (!status.over_plen) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.count_zero) begin
          state_next = ST_END;
        end else if (status.prefix) begin
          state_next = status.at_plen ? ST_REPL : ST_END;
        end
      end
      ST_REPL: begin
        if (!status.repl_more) begin
          state_next = ST_END;
        end
      end
      ST_LIM_DRAIN: begin
        if (status.count_zero) begin
          state_next = ST_LIM_BYTE;
        end
      end
      ST_LIM_BYTE: begin
        if (status.emit_ok) begin
          state_next = ST_END;
        end
      end
      ST_END: begin
        if ((!status.cur_last || status.count_zero) && status.emit_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.append    = 1'b0;
    cmd.emit      = EMIT_NONE;
    cmd.repl_done = 1'b0;
    cmd.finish    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_APPEND: begin
        if (!status.count_full) begin
          cmd.append = 1'b1;
        end else if (status.emit_ok) begin
          cmd.emit = EMIT_OLDEST;
        end
      end
      ST_TRIM: begin
        if (status.over_plen && status.emit_ok) begin
          cmd.emit = EMIT_OLDEST;
        end
      end
      ST_SCAN: begin
        if (!status.count_zero && !status.prefix && status.emit_ok) begin
          cmd.emit = EMIT_OLDEST;
        end
      end
      ST_REPL: begin
        if (!status.repl_more) begin
          cmd.repl_done = 1'b1;
        end else if (status.emit_ok) begin
          cmd.emit = EMIT_REPL;
        end
      end
      ST_LIM_DRAIN: begin
        if (!status.count_zero && status.emit_ok) begin
          cmd.emit = EMIT_OLDEST;
        end
      end
      ST_LIM_BYTE: begin
        if (status.emit_ok) begin
          cmd.emit = EMIT_CUR;
        end
      end
      ST_END: begin
        if (status.emit_ok) begin
          if (status.cur_last && !status.count_zero) begin
            cmd.emit = EMIT_OLDEST;
          end else begin
            cmd.finish = 1'b1;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* src/sfr_datapath.sv */
// Datapath: configuration registers, hold buffer, match logic and output register.
module sfr_datapath #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [sfr_pkg::BYTE_W-1:0]         in_byte,
  input  logic                               in_last,
  input  sfr_pkg::cmd_t                      cmd,
  output sfr_pkg::status_t                   status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_last
);
  import sfr_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
  localparam int HIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int RCNT_W = $clog2(MAX_REPLACEMENT + 2);

  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]      pattern_length;
  logic [CFG_DATA_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]      replacement_length;
  logic                  replace_all;
  logic [LIMIT_W-1:0]    max_replacements;

  logic [BYTE_W-1:0]  hold [MAX_PATTERN];
  logic [CNT_W-1:0]   count;
  logic [LIMIT_W-1:0] done;
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_last;
  logic [RCNT_W-1:0]  ridx;
  logic [BYTE_W-1:0]  pend_byte;
  logic               pend_v;

  logic [CNT_W-1:0]   plen;
  logic [RCNT_W-1:0]  rlen;
  logic [LIMIT_W-1:0] limit_eff;
  logic               prefix;
  logic [LANE_W-1:0]  rlane;
  logic [BYTE_W-1:0]  emit_byte;
  logic               emitting;
  logic               push;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
      replace_all        <= 1'b1;
      max_replacements   <= LIMIT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
        REG_REPLACE_ALL:        replace_all        <= cfg_data[0];
        REG_MAX_REPLACEMENTS:   max_replacements   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      plen = CNT_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      plen = CNT_W'(MAX_PATTERN);
    end else begin
      plen = CNT_W'(pattern_length);
    end
    if (replacement_length > LEN_W'(MAX_REPLACEMENT)) begin
      rlen = RCNT_W'(MAX_REPLACEMENT);
    end else begin
      rlen = RCNT_W'(replacement_length);
    end
  end

  always_comb begin
    prefix = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CNT_W'(i) < count) && (hold[i] != pattern_bytes[8*i +: 8])) begin
        prefix = 1'b0;
      end
    end
  end

  assign limit_eff = (max_replacements == '0) ? LIMIT_W'(1) : max_replacements;
  assign rlane     = LANE_W'(ridx);

  always_comb begin
    unique case (cmd.emit)
      EMIT_OLDEST: emit_byte = hold[0];
      EMIT_CUR:    emit_byte = cur_byte;
      EMIT_REPL:   emit_byte = replacement_bytes[{rlane, 3'b000} +: 8];
      default:     emit_byte = hold[0];
    endcase
  end

  assign emitting = (cmd.emit != EMIT_NONE);
  assign push     = (emitting || cmd.finish) && pend_v;

  assign status.limit      = !replace_all && (done >= limit_eff);
  assign status.count_zero = (count == '0);
  assign status.count_full = (count == CNT_W'(MAX_PATTERN));
  assign status.over_plen  = (count > plen);
  assign status.prefix     = prefix;
  assign status.at_plen    = (count == plen);
  assign status.repl_more  = (ridx < rlen);
  assign status.emit_ok    = !pend_v || !out_valid || out_ready;
  assign status.cur_last   = cur_last;

  // hold buffer: shift out at the head, append at the fill point
  always_ff @(posedge clk) begin
    if (cmd.emit == EMIT_OLDEST) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        hold[i] <= hold[i+1];
      end
    end else if (cmd.append) begin
      hold[count[HIDX_W-1:0]] <= cur_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_byte <= in_byte;
    end
    if (emitting) begin
      pend_byte <= emit_byte;
    end
    if (push) begin
      out_byte <= pend_byte;
      out_last <= cmd.finish && cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      done      <= '0;
      cur_last  <= 1'b0;
      ridx      <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        cur_last <= in_last;
        ridx     <= '0;
      end
      if (cmd.append) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.emit == EMIT_OLDEST) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.emit == EMIT_REPL) begin
        ridx <= ridx + RCNT_W'(1);
      end
      if (cmd.repl_done) begin
        count <= '0;
        if (done != '1) begin
          done <= done + LIMIT_W'(1);
        end
      end
      if (cmd.finish && cur_last) begin
        count <= '0;
        done  <= '0;
      end
      if (emitting) begin
        pend_v <= 1'b1;
      end else if (cmd.finish) begin
        pend_v <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/stream_find_and_replace.sv */
// Top level of the stream find-and-replace block.
//
// Input channel in_valid/in_ready carries one byte per item, in_last on the
// final byte of a string. Output channel out_valid/out_ready carries the
// rewritten string, out_last on its final byte. Registers are written through
// cfg_write/cfg_index/cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. One item is processed at
// a time. Below the replacement limit an item passes through accept, append,
// trim, scan and end, with a step for each byte emitted and one more when a
// match is replaced; at the limit it passes through accept, drain of the held
// bytes, the item's own byte and end. At most 16 bytes leave per item; the
// hold buffer has a single shift-out port and the emit path carries one byte
// at a time. The last byte of each item is staged in a pending register so
// out_last can be placed, then sent with the item's end.
// Reset clears the hold buffer fill, the replacement count and the output
// valid flag and restores the register defaults. When the receiver stalls the
// output register holds its byte and the controller waits before emitting
// further bytes; in_ready stays low until the item's work is finished.
module stream_find_and_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_last
);
  import sfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfr_datapath #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

/* src/sfr_checker.sv */
// Port-level checks for the stream find-and-replace block, bound to the top level.
module sfr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [sfr_pkg::BYTE_W-1:0]      in_byte,
  input logic                            in_last,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sfr_pkg::BYTE_W-1:0]      out_byte,
  input logic                            out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output item changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("waiting input item changed");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);

/* dv/sfr_rewrite_checker.sv */
// Checker for the stream find-and-replace block: predicts the rewritten stream and compares it.
module sfr_rewrite_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            in_last,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]      out_byte,
  input  logic                            out_last,
  output int                              mismatches,
  output int                              bytes_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int MAX_BURST    = 16;
  localparam int COUNT_MAX    = 65535;
  localparam int REPORT_LINES = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } rw_item_t;

  rw_item_t rewritten_q[$];

  logic [CFG_DATA_W-1:0] pattern_word;
  logic [LEN_W-1:0]      pattern_len;
  logic [CFG_DATA_W-1:0] replacement_word;
  logic [LEN_W-1:0]      replacement_len;
  logic                  replace_every;
  logic [LIMIT_W-1:0]    replace_cap;

  logic [BYTE_W-1:0] held [MAX_PATTERN_DEF];
  int                held_count;
  int                replaced;
  int                burst_len;

  task automatic push_result(input logic [BYTE_W-1:0] d);
    rw_item_t res;
    res.data = d;
    res.last = 1'b0;
    if (burst_len < MAX_BURST) begin
      rewritten_q.insert(rewritten_q.size(), res);
      burst_len++;
    end
  endtask

  task automatic shift_oldest();
    int i;
    if (held_count > 0) begin
      push_result(held[0]);
      for (i = 0; i < MAX_PATTERN_DEF - 1; i++) held[i] = held[i + 1];
      held[MAX_PATTERN_DEF - 1] = '0;
      held_count--;
    end
  endtask

  task automatic rewrite_byte(input logic [BYTE_W-1:0] d, input logic eos);
    int       plen;
    int       rlen;
    int       cap;
    int       i;
    logic     is_prefix;
    plen = (pattern_len == 0) ? 1 : int'(pattern_len);
    if (plen > MAX_PATTERN_DEF) plen = MAX_PATTERN_DEF;
    rlen = (replacement_len > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : int'(replacement_len);
    cap = (replace_cap == 0) ? 1 : int'(replace_cap);
    burst_len = 0;
    if (!replace_every && replaced >= cap) begin
      while (held_count > 0) shift_oldest();
      push_result(d);
    end else begin
      while (held_count >= MAX_PATTERN_DEF) shift_oldest();
      held[held_count] = d;
      held_count++;
      while (held_count > plen) shift_oldest();
      while (held_count > 0) begin
        is_prefix = 1'b1;
        for (i = 0; i < held_count; i++) begin
          if (held[i] != pattern_word[8*i +: 8]) is_prefix = 1'b0;
        end
        if (is_prefix) begin
          if (held_count == plen) begin
            for (i = 0; i < rlen; i++) push_result(replacement_word[8*i +: 8]);
            for (i = 0; i < MAX_PATTERN_DEF; i++) held[i] = '0;
            held_count = 0;
            if (replaced < COUNT_MAX) replaced++;
          end
          break;
        end
        shift_oldest();
      end
    end
    if (eos) begin
      while (held_count > 0) shift_oldest();
      held_count = 0;
      replaced = 0;
      if (burst_len > 0) begin
        rewritten_q[rewritten_q.size() - 1].last = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < REPORT_LINES)
      $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    rw_item_t want;
    if (rewritten_q.size() == 0) begin
      report_mismatch("item with nothing pending", 16'({out_byte, out_last}), '0);
    end else begin
      want = rewritten_q.pop_front();
      if (out_byte !== want.data)
        report_mismatch("out_byte", 16'(out_byte), 16'(want.data));
      if (out_last !== want.last)
        report_mismatch("out_last", 16'(out_last), 16'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pattern_word     = '0;
      pattern_len      = LEN_W'(1);
      replacement_word = '0;
      replacement_len  = '0;
      replace_every    = 1'b1;
      replace_cap      = LIMIT_W'(1);
      foreach (held[k]) held[k] = '0;
      held_count = 0;
      replaced   = 0;
      mismatches = 0;
      rewritten_q.delete();
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PATTERN_BYTES:      pattern_word = cfg_data;
          REG_PATTERN_LENGTH:     pattern_len = cfg_data[LEN_W-1:0];
          REG_REPLACEMENT_BYTES:  replacement_word = cfg_data;
          REG_REPLACEMENT_LENGTH: replacement_len = cfg_data[LEN_W-1:0];
          REG_REPLACE_ALL:        replace_every = cfg_data[0];
          REG_MAX_REPLACEMENTS:   replace_cap = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) rewrite_byte(in_byte, in_last);
      if (out_valid && out_ready) check_result();
    end
    bytes_owed = rewritten_q.size();
  end

endmodule

/* dv/tb.sv */
// Testbench top for the stream find-and-replace block: stimulus, register set-up and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_ITEMS     = 140;
  localparam int SATURATE_ITEMS  = 16;

  typedef struct {
    logic [CFG_DATA_W-1:0] pat;
    logic [LEN_W-1:0]      plen;
    logic [CFG_DATA_W-1:0] rep;
    logic [LEN_W-1:0]      rlen;
    logic                  every;
    logic [LIMIT_W-1:0]    cap;
  } rule_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [BYTE_W-1:0]      in_byte;
  logic                   in_last;
  logic                   out_valid;
  logic                   out_ready;
  logic [BYTE_W-1:0]      out_byte;
  logic                   out_last;
  int                     mismatches;
  int                     bytes_owed;

  int    src_idle = 0;
  int    dst_idle = 0;
  bit    stall_req = 1'b0;
  rule_t current;

  stream_find_and_replace dut (.*);

  sfr_rewrite_checker rewrite_chk (.*);

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        stall_req = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= dst_idle);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) quiet = 0;
      else quiet++;
    end
    $display("tb NOT OK");
    $finish;
  end

  task automatic send(input logic [BYTE_W-1:0] d, input logic eos);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= d;
    in_last  <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_seq(input logic [BYTE_W-1:0] s[$], input logic eos);
    int i;
    for (i = 0; i < s.size(); i++) send(s[i], eos && (i == s.size() - 1));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic apply_rule(input rule_t r);
    settle();
    current = r;
    write_reg(REG_PATTERN_BYTES, r.pat);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(r.plen));
    write_reg(REG_REPLACEMENT_BYTES, r.rep);
    write_reg(REG_REPLACEMENT_LENGTH, CFG_DATA_W'(r.rlen));
    write_reg(REG_REPLACE_ALL, CFG_DATA_W'(r.every));
    write_reg(REG_MAX_REPLACEMENTS, CFG_DATA_W'(r.cap));
    cfg_write <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    unique case ($urandom_range(0, 3))
      0, 1:    return BYTE_W'(8'h41 + $urandom_range(0, 2));
      2:       return current.pat[8*$urandom_range(0, 7) +: 8];
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic rule_t random_rule();
    rule_t r;
    int    i;
    for (i = 0; i < 8; i++)
      r.pat[8*i +: 8] = ($urandom_range(0, 4) != 0) ? BYTE_W'(8'h41 + $urandom_range(0, 2))
                                                    : BYTE_W'($urandom);
    if ($urandom_range(0, 4) != 0) r.plen = LEN_W'($urandom_range(1, 8));
    else r.plen = $urandom_range(0, 1) ? LEN_W'(0) : LEN_W'($urandom_range(9, 15));
    r.rep = {$urandom, $urandom};
    if ($urandom_range(0, 6) != 0) r.rlen = LEN_W'($urandom_range(0, 8));
    else r.rlen = LEN_W'($urandom_range(9, 15));
    r.every = 1'($urandom_range(0, 1));
    unique case ($urandom_range(0, 9))
      0:       r.cap = '1;
      1:       r.cap = LIMIT_W'($urandom);
      default: r.cap = LIMIT_W'($urandom_range(0, 3));
    endcase
    return r;
  endfunction

  task automatic send_random_string(inout int sent);
    logic [BYTE_W-1:0] s[$];
    int                len;
    int                plen;
    int                k;
    int                j;
    plen = (current.plen == 0) ? 1 : ((current.plen > 8) ? 8 : int'(current.plen));
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
    while (s.size() < len) begin
      if ($urandom_range(0, 9) < 6) begin
        k = $urandom_range(0, 1) ? plen : $urandom_range(1, plen);
        for (j = 0; j < k; j++) s.insert(s.size(), current.pat[8*j +: 8]);
        if ($urandom_range(0, 3) == 0) s[s.size() - 1 - $urandom_range(0, k - 1)] = pick_byte();
      end else begin
        s.insert(s.size(), pick_byte());
      end
    end
    send_seq(s, $urandom_range(0, 9) != 0);
    sent += s.size();
  endtask

  task automatic run_phase(input int src_pct, input int dst_pct, input bit hold_off);
    int sent;
    int since_rule;
    src_idle = src_pct;
    dst_idle = dst_pct;
    sent = 0;
    since_rule = 0;
    apply_rule(random_rule());
    if (hold_off) stall_req = 1'b1;
    while (sent < PHASE_ITEMS) begin
      if (since_rule > 40) begin
        apply_rule(random_rule());
        since_rule = 0;
      end
      k_send(sent, since_rule);
    end
  endtask

  task automatic k_send(inout int sent, inout int since_rule);
    int before_count;
    before_count = sent;
    send_random_string(sent);
    since_rule += sent - before_count;
  endtask

  task automatic directed();
    rule_t r;
    send_seq('{8'h00, 8'hFF, 8'h00}, 1'b1);
    r.pat   = '1;
    r.plen  = LEN_W'(15);
    r.rep   = 64'h0123_4567_89AB_CDEF;
    r.rlen  = LEN_W'(15);
    r.every = 1'b1;
    r.cap   = '0;
    apply_rule(r);
    send_seq('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b1);
    r.pat   = 64'h4443_4241;
    r.plen  = LEN_W'(4);
    r.rep   = 64'h7978;
    r.rlen  = LEN_W'(2);
    r.every = 1'b0;
    r.cap   = '0;
    apply_rule(r);
    send_seq('{8'h41, 8'h42, 8'h41, 8'h42, 8'h43, 8'h44, 8'h41, 8'h42, 8'h43, 8'h44}, 1'b1);
    send_seq('{8'h41, 8'h42, 8'h43}, 1'b0);
    r.plen = '0;
    apply_rule(r);
    send_seq('{8'h41}, 1'b1);
  endtask

  task automatic saturate();
    rule_t r;
    int    i;
    src_idle = 0;
    dst_idle = 0;
    r.pat   = 64'h5A;
    r.plen  = LEN_W'(1);
    r.rep   = '0;
    r.rlen  = '0;
    r.every = 1'b1;
    r.cap   = '1;
    apply_rule(r);
    for (i = 0; i < SATURATE_ITEMS; i++) send(8'h5A, 1'b0);
    r.every = 1'b0;
    apply_rule(r);
    send_seq('{8'h5A, 8'h33}, 1'b1);
  endtask

  initial begin : stimulus
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_byte   = '0;
    in_last   = 1'b0;
    src_idle  = 7;
    dst_idle  = 50;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed();
    run_phase(7, 50, 1'b1);
    run_phase(50, 7, 1'b0);
    run_phase(0, 0, 1'b0);
    saturate();
    settle();
    if (mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
